>>> hw/rtl/rfj_pkg.sv
`timescale 1ns / 1ps

package rfj_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = 10;
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_ELIM = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

    typedef struct packed {
        logic start;
        logic rd_en;
        logic move;
        logic commit;
    } rfj_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic step_zero;
        logic moves_zero;
        logic out_free;
    } rfj_status_t;

    function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/rfj_ctrl.sv
`timescale 1ns / 1ps

module rfj_ctrl import rfj_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_opcode,
    input  rfj_status_t       status,
    output rfj_cmd_t          cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_MOVE = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_opcode)
                        OP_DEQ:  state_next = status.count_zero ? S_DONE : S_READ;
                        OP_ELIM: state_next = (status.count_zero || status.step_zero) ?
                                              S_DONE : S_READ;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                // Each read either feeds one more move or is the final removal.
                state_next = status.moves_zero ? S_DONE : S_MOVE;
            end
            S_MOVE: begin
                state_next = S_READ;
            end
            S_DONE: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign cmd.start  = s_ready && s_valid;
    assign cmd.rd_en  = (state_reg == S_READ);
    assign cmd.move   = (state_reg == S_MOVE);
    assign cmd.commit = (state_reg == S_DONE) && status.out_free;

    // A move is always followed by the read of the next head word.
    a_move_then_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.move |=> cmd.rd_en)
        else $error("move not followed by a head read");

endmodule

>>> hw/rtl/rfj_datapath.sv
`timescale 1ns / 1ps

module rfj_datapath import rfj_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [STEP_W-1:0]        cfg_wr_data,
    input  logic [OP_W-1:0]          s_opcode,
    input  logic signed [DATA_W-1:0] s_data_in,
    input  rfj_cmd_t                 cmd,
    output rfj_status_t              status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_ok,
    output logic signed [DATA_W-1:0] m_data_out,
    output logic [CNT_W-1:0]         m_fill_count
);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] moves_reg;
    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] din_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] tail_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_valid_reg;
    logic              ok_reg;
    logic [DATA_W-1:0] dout_reg;
    logic [CNT_W-1:0]  fill_reg;

    logic              full;
    logic              enq_ok;
    logic              pop_ok;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic              head_adv;
    logic              tail_adv;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign enq_ok = (op_reg == OP_ENQ) && !full;
    assign pop_ok = ((op_reg == OP_DEQ) || ((op_reg == OP_ELIM) && status.step_zero == 1'b0))
                    && !status.count_zero;

    assign status.count_zero = (count_reg == '0);
    assign status.step_zero  = (step_reg == '0);
    assign status.moves_zero = (moves_reg == '0);
    assign status.out_free   = !m_valid_reg || m_ready;

    // A move copies the word just read at the head to the tail slot.
    assign wr_en    = cmd.move || (cmd.commit && enq_ok);
    assign wr_data  = cmd.move ? rd_data_reg : din_reg;
    assign head_adv = cmd.move || (cmd.commit && pop_ok);
    assign tail_adv = wr_en;

    always_comb begin
        count_next = count_reg;
        if (cmd.commit && enq_ok) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.commit && pop_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= s_opcode;
            din_reg <= s_data_in;
        end
        if (cmd.commit) begin
            ok_reg   <= enq_ok || pop_ok;
            dout_reg <= pop_ok ? rd_data_reg : '0;
            fill_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_RESET;
            moves_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            if (cmd.start) begin
                moves_reg <= ((s_opcode == OP_ELIM) && (step_reg != '0)) ?
                             step_reg - 1'b1 : '0;
            end else if (cmd.move) begin
                moves_reg <= moves_reg - 1'b1;
            end
            if (head_adv) begin
                head_reg <= next_ptr(head_reg);
            end
            if (tail_adv) begin
                tail_reg <= next_ptr(tail_reg);
            end
            count_reg <= count_next;
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = ok_reg;
    assign m_data_out   = dout_reg;
    assign m_fill_count = fill_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above ring depth");

    // Moving a word from head to tail never changes the fill.
    a_move_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.move |=> $stable(count_reg))
        else $error("fill count changed during a move");

    a_move_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.move |-> !status.count_zero)
        else $error("move issued on an empty ring");

endmodule

>>> hw/rtl/ring_fifo_with_josephus_step.sv
`timescale 1ns / 1ps

// Ring FIFO of 64 signed words with enqueue, dequeue and one Josephus elimination
// round, where k comes from the step_reg register (reset value 1). It is to be written
// through cfg_wr_en/cfg_wr_data only while the block is idle; the user must keep to it,
// as the block itself does not enforce it. Every accepted item gives exactly one result.
// Enqueue and unused opcodes go straight to loading the result; dequeue first reads the
// head word unless the ring is empty. Eliminate, with k above zero on a non-empty ring,
// walks k-1 head-to-tail moves, each a memory read state followed by a write state
// through the ring memory, then one read for the removed word and a final state that
// loads the result. The result sits in an output register, so the next item is accepted
// while an earlier result still waits on m_ready.
module ring_fifo_with_josephus_step import rfj_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [STEP_W-1:0]        cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_opcode,
    input  logic signed [DATA_W-1:0] s_data_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_ok,
    output logic signed [DATA_W-1:0] m_data_out,
    output logic [CNT_W-1:0]         m_fill_count
);

    rfj_cmd_t    cmd;
    rfj_status_t status;

    rfj_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .status   (status),
        .cmd      (cmd)
    );

    rfj_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_opcode     (s_opcode),
        .s_data_in    (s_data_in),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ok         (m_ok),
        .m_data_out   (m_data_out),
        .m_fill_count (m_fill_count)
    );

    // A result is only loaded once the previous one has left or is leaving.
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("result overwrote a pending item");

    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("committed result not presented");

endmodule
